// File: hdl/fixed_frame_command_parser_macros.svh
// Assertion macros shared by the parser modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef FIXED_FRAME_COMMAND_PARSER_MACROS_SVH
`define FIXED_FRAME_COMMAND_PARSER_MACROS_SVH

// The consequent must hold at the same edge as the antecedent.
`define FFCP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold at the edge after the antecedent.
`define FFCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/ffcp_pkg.sv
package ffcp_pkg;

  localparam int FRAME_LEN = 8;
  localparam int SET_CMDS  = 6;
  localparam int KEY_CMDS  = 4;

  typedef logic [7:0] byte_t;

  // Byte 0 of a frame sits in the top byte, so string literals compare directly.
  typedef logic [8*FRAME_LEN-1:0] frame_t;
  typedef logic [8*(FRAME_LEN-1)-1:0] partial_t;

  typedef enum logic [3:0] {
    CMD_NONE  = 4'd0,
    CMD_AH    = 4'd1,
    CMD_AL    = 4'd2,
    CMD_CH    = 4'd3,
    CMD_CL    = 4'd4,
    CMD_SH    = 4'd5,
    CMD_SL    = 4'd6,
    CMD_K0001 = 4'd7,
    CMD_K0000 = 4'd8,
    CMD_K0010 = 4'd9,
    CMD_K0011 = 4'd10
  } cmd_e;

  typedef struct packed {
    cmd_e               command;
    logic signed [15:0] value;
  } result_t;

  localparam logic [31:0] SET_HEADS [SET_CMDS] = '{
    "<WAH", "<WAL", "<WCH", "<WCL", "<WSH", "<WSL"
  };

  localparam cmd_e SET_CODES [SET_CMDS] = '{
    CMD_AH, CMD_AL, CMD_CH, CMD_CL, CMD_SH, CMD_SL
  };

  localparam frame_t KEY_FRAMES [KEY_CMDS] = '{
    "<WK0001>", "<WK0000>", "<WK0010>", "<WK0011>"
  };

  localparam cmd_e KEY_CODES [KEY_CMDS] = '{
    CMD_K0001, CMD_K0000, CMD_K0010, CMD_K0011
  };

  localparam byte_t CLOSE_CHAR = ">";
  localparam byte_t ZERO_CHAR  = "0";

endpackage

// File: hdl/ffcp_if.sv
interface ffcp_byte_if;
  logic                valid;
  logic                ready;
  ffcp_pkg::byte_t     rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ffcp_result_if;
  logic                valid;
  logic                ready;
  logic [3:0]          command;
  logic signed [15:0]  value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

// File: hdl/ffcp_gather.sv
`include "fixed_frame_command_parser_macros.svh"

module ffcp_gather (
  input  logic                 clk,
  input  logic                 rst,
  ffcp_byte_if.sink            rx,
  output logic                 frame_valid,
  input  logic                 frame_ready,
  output ffcp_pkg::frame_t     frame
);

  logic [2:0]          byte_count;
  ffcp_pkg::partial_t  partial;
  logic                rx_accept;
  logic                last_byte;

  assign last_byte = (byte_count == 3'(ffcp_pkg::FRAME_LEN - 1));
  assign rx.ready  = !last_byte || !frame_valid || frame_ready;
  assign rx_accept = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= 3'd0;
      frame_valid <= 1'b0;
    end else begin
      if (rx_accept) begin
        byte_count <= byte_count + 3'd1;
      end
      if (rx_accept && last_byte) begin
        frame_valid <= 1'b1;
      end else if (frame_ready) begin
        frame_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_accept && !last_byte) begin
      partial <= {partial[8*(ffcp_pkg::FRAME_LEN-2)-1:0], rx.rx_byte};
    end
    if (rx_accept && last_byte) begin
      frame <= {partial, rx.rx_byte};
    end
  end

  `FFCP_ASSERT_NEXT(a_frame_loads, rx_accept && last_byte, frame_valid)
  `FFCP_ASSERT_NEXT(a_count_steps, rx_accept && !last_byte,
                    byte_count == $past(byte_count) + 3'd1)

endmodule

// File: hdl/ffcp_classify.sv
module ffcp_classify (
  input  ffcp_pkg::frame_t   frame,
  output ffcp_pkg::result_t  result
);

  logic signed [15:0] d_hund;
  logic signed [15:0] d_tens;
  logic signed [15:0] d_ones;
  logic signed [15:0] digits;

  assign d_hund = signed'(16'(frame[31:24]) - 16'(ffcp_pkg::ZERO_CHAR));
  assign d_tens = signed'(16'(frame[23:16]) - 16'(ffcp_pkg::ZERO_CHAR));
  assign d_ones = signed'(16'(frame[15:8]) - 16'(ffcp_pkg::ZERO_CHAR));
  assign digits = 16'(d_hund * 16'sd100) + 16'(d_tens * 16'sd10) + d_ones;

  // Later matches overwrite earlier ones, so the loops run from the highest index down
  // and setting commands take precedence over key commands.
  always_comb begin
    result.command = ffcp_pkg::CMD_NONE;
    result.value   = 16'sd0;
    for (int i = ffcp_pkg::KEY_CMDS - 1; i >= 0; i--) begin
      if (frame == ffcp_pkg::KEY_FRAMES[i]) begin
        result.command = ffcp_pkg::KEY_CODES[i];
      end
    end
    if (frame[7:0] == ffcp_pkg::CLOSE_CHAR) begin
      for (int i = ffcp_pkg::SET_CMDS - 1; i >= 0; i--) begin
        if (frame[63:32] == ffcp_pkg::SET_HEADS[i]) begin
          result.command = ffcp_pkg::SET_CODES[i];
          result.value   = digits;
        end
      end
    end
  end

endmodule

// File: hdl/fixed_frame_command_parser.sv
// Gathers received bytes into fixed frames of eight bytes and gives one result beat per
// frame: the command code (zero for an unrecognized frame) and, for the six setting
// commands, the three-digit value converted without any check on the digits. A byte
// beat is taken in every cycle unless held back as below. The first seven bytes of a
// frame are never held back; the eighth waits only when the frame register is still full
// and the result register is stalled. After the eighth byte is taken, the frame is held
// in the frame register and then in the result register, with matching and digit
// conversion done between the two.
`include "fixed_frame_command_parser_macros.svh"

module fixed_frame_command_parser (
  input  logic          clk,
  input  logic          rst,
  ffcp_byte_if.sink     rx,
  ffcp_result_if.source res
);

  logic               frame_valid;
  logic               frame_ready;
  ffcp_pkg::frame_t   frame;
  ffcp_pkg::result_t  result_next;
  ffcp_pkg::result_t  result;
  logic               out_valid;

  ffcp_gather u_gather (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  ffcp_classify u_classify (
    .frame  (frame),
    .result (result_next)
  );

  assign frame_ready = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_ready) begin
      out_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      result <= result_next;
    end
  end

  assign res.valid   = out_valid;
  assign res.command = result.command;
  assign res.value   = result.value;

  `FFCP_ASSERT_NEXT(a_frame_to_result, frame_valid && frame_ready, res.valid)
  `FFCP_ASSERT_SAME(a_value_only_for_settings,
                    res.valid && (res.command == ffcp_pkg::CMD_NONE ||
                                  res.command >= ffcp_pkg::CMD_K0001),
                    res.value == 16'sd0)

endmodule
